// File: design/nnir_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nnir_pkg
// Shared constants for the nearest neighbor resampler: frame store geometry,
// field widths, configuration register indexes and function and status codes.
// ----------------------------------------------------------------------------
package nnir_pkg;

  localparam int MAX_SOURCE_WIDTH  = 64;
  localparam int MAX_SOURCE_HEIGHT = 64;

  localparam int SRC_COL_W  = 6;   // source column field width
  localparam int SRC_ROW_W  = 6;   // source row field width
  localparam int COORD_W    = 12;  // input coordinate width
  localparam int PIXEL_W    = 8;
  localparam int SRC_SIZE_W = 7;
  localparam int TGT_SIZE_W = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  localparam int STORE_DEPTH = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // quotient is always below the source size
  localparam int QUOT_W = SRC_COL_W;
  // source size times odd target coordinate
  localparam int NUM_W  = SRC_SIZE_W + TGT_SIZE_W;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = 2'd3;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_FETCH = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

endpackage
`default_nettype wire

// File: design/nnir_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nnir_req_if
// Request channel: load or fetch transactions with valid/ready handshake.
// ----------------------------------------------------------------------------
interface nnir_req_if import nnir_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [COORD_W-1:0] column;
  logic [COORD_W-1:0] row;
  logic [PIXEL_W-1:0] pixel_in;

  modport source (output valid, func, column, row, pixel_in, input ready);
  modport sink   (input valid, func, column, row, pixel_in, output ready);
endinterface
`default_nettype wire

// File: design/nnir_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nnir_rsp_if
// Response channel: fetched pixel, mapped source coordinates and status.
// ----------------------------------------------------------------------------
interface nnir_rsp_if import nnir_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [PIXEL_W-1:0]   pixel_out;
  logic [SRC_COL_W-1:0] source_column;
  logic [SRC_ROW_W-1:0] source_row;
  logic                 status;

  modport source (output valid, pixel_out, source_column, source_row, status,
                  input ready);
  modport sink   (input valid, pixel_out, source_column, source_row, status,
                  output ready);
endinterface
`default_nettype wire

// File: design/nearest_neighbour_image_resampler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_neighbour_image_resampler
// Nearest neighbor scaler with a built-in 64x64 byte source frame store.
// ----------------------------------------------------------------------------
// a load or out-of-frame fetch goes from request transaction straight to S_DONE
//   and the response register; an in-frame fetch passes S_MUL, S_DIV, S_READ, S_DONE
// one transaction at a time; the next request is taken only back in S_IDLE, after
//   the multiply, 6-step divider and store read for an in-frame fetch; the response
//   register lets the next request in while it waits
// reset: sizes return to 64x64 source and 64x64 target; store contents undefined
module nearest_neighbour_image_resampler
  import nnir_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  nnir_req_if.sink                   req,
  nnir_rsp_if.source                 rsp,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state;

  // configuration
  logic [SRC_SIZE_W-1:0] source_width;
  logic [SRC_SIZE_W-1:0] source_height;
  logic [TGT_SIZE_W-1:0] target_width;
  logic [TGT_SIZE_W-1:0] target_height;
  logic [SRC_SIZE_W-1:0] sw_eff;
  logic [SRC_SIZE_W-1:0] sh_eff;

  // captured request
  logic [COORD_W-1:0] col_q;
  logic [COORD_W-1:0] row_q;

  // divider
  logic [NUM_W-1:0]  rem_c;
  logic [NUM_W-1:0]  rem_r;
  logic [NUM_W-1:0]  dsh_c;
  logic [NUM_W-1:0]  dsh_r;
  logic [QUOT_W-1:0] quot_c;
  logic [QUOT_W-1:0] quot_r;
  logic [2:0]        step;
  logic              ge_c;
  logic              ge_r;

  // result staging
  logic res_fetch;
  logic res_status;

  // frame store
  logic [PIXEL_W-1:0] store [STORE_DEPTH];
  logic [PIXEL_W-1:0] rd_data;
  logic               store_we;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ADDR_W-1:0]  rd_addr;

  logic accept;
  logic load_in_range;
  logic fetch_in_range;
  logic rsp_free;

  always_comb begin
    if (source_width == '0) begin
      sw_eff = SRC_SIZE_W'(1);
    end else if (source_width > SRC_SIZE_W'(MAX_SOURCE_WIDTH)) begin
      sw_eff = SRC_SIZE_W'(MAX_SOURCE_WIDTH);
    end else begin
      sw_eff = source_width;
    end
    if (source_height == '0) begin
      sh_eff = SRC_SIZE_W'(1);
    end else if (source_height > SRC_SIZE_W'(MAX_SOURCE_HEIGHT)) begin
      sh_eff = SRC_SIZE_W'(MAX_SOURCE_HEIGHT);
    end else begin
      sh_eff = source_height;
    end
  end

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign rsp_free  = !rsp.valid || rsp.ready;

  assign load_in_range = (req.column < COORD_W'(sw_eff)) &&
                         (req.row < COORD_W'(sh_eff));
  assign fetch_in_range = ({1'b0, req.column} < target_width) &&
                          ({1'b0, req.row} < target_height);

  assign store_we = accept && (req.func == FUNC_LOAD) && load_in_range;
  assign wr_addr  = {req.row[SRC_ROW_W-1:0], req.column[SRC_COL_W-1:0]};
  assign rd_addr  = {quot_r, quot_c};

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= SRC_SIZE_W'(MAX_SOURCE_WIDTH);
      source_height <= SRC_SIZE_W'(MAX_SOURCE_HEIGHT);
      target_width  <= TGT_SIZE_W'(64);
      target_height <= TGT_SIZE_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SOURCE_WIDTH:  source_width  <= cfg_data[SRC_SIZE_W-1:0];
        REG_SOURCE_HEIGHT: source_height <= cfg_data[SRC_SIZE_W-1:0];
        REG_TARGET_WIDTH:  target_width  <= cfg_data[TGT_SIZE_W-1:0];
        REG_TARGET_HEIGHT: target_height <= cfg_data[TGT_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store[wr_addr] <= req.pixel_in;
    end
    if (state == S_READ) begin
      rd_data <= store[rd_addr];
    end
  end

  // one restoring step per axis: check whether the shifted divisor fits; S_DIV subtracts it
  always_comb begin
    ge_c   = rem_c >= dsh_c;
    ge_r   = rem_r >= dsh_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp.valid <= 1'b0;
      step      <= '0;
    end else begin
      // in S_DONE the response register is reloaded instead
      if (rsp.valid && rsp.ready && (state != S_DONE)) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            col_q <= req.column;
            row_q <= req.row;
            if (req.func == FUNC_LOAD) begin
              res_fetch  <= 1'b0;
              res_status <= load_in_range ? STATUS_OK : STATUS_RANGE;
              state      <= S_DONE;
            end else if (!fetch_in_range) begin
              res_fetch  <= 1'b0;
              res_status <= STATUS_RANGE;
              state      <= S_DONE;
            end else begin
              res_fetch  <= 1'b1;
              res_status <= STATUS_OK;
              state      <= S_MUL;
            end
          end
        end
        S_MUL: begin
          rem_c  <= NUM_W'(sw_eff) * NUM_W'({col_q, 1'b1});
          rem_r  <= NUM_W'(sh_eff) * NUM_W'({row_q, 1'b1});
          dsh_c  <= NUM_W'({target_width, 1'b0}) << (QUOT_W - 1);
          dsh_r  <= NUM_W'({target_height, 1'b0}) << (QUOT_W - 1);
          quot_c <= '0;
          quot_r <= '0;
          step   <= '0;
          state  <= S_DIV;
        end
        S_DIV: begin
          if (ge_c) begin
            rem_c <= rem_c - dsh_c;
          end
          if (ge_r) begin
            rem_r <= rem_r - dsh_r;
          end
          quot_c <= {quot_c[QUOT_W-2:0], ge_c};
          quot_r <= {quot_r[QUOT_W-2:0], ge_r};
          dsh_c  <= dsh_c >> 1;
          dsh_r  <= dsh_r >> 1;
          step   <= step + 3'd1;
          if (step == 3'(QUOT_W - 1)) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (rsp_free) begin
            rsp.valid         <= 1'b1;
            rsp.status        <= res_status;
            rsp.pixel_out     <= res_fetch ? rd_data : '0;
            rsp.source_column <= res_fetch ? quot_c : '0;
            rsp.source_row    <= res_fetch ? quot_r : '0;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // a load never enters the divider
  a_load_direct: assert property (@(posedge clk) disable iff (rst)
    accept && (req.func == FUNC_LOAD) |=> state == S_DONE)
    else $error("load transaction did not go straight to completion");

  // mapped coordinates stay inside the clamped source frame
  a_quot_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> ({1'b0, quot_c} < sw_eff) && ({1'b0, quot_r} < sh_eff))
    else $error("mapped source coordinate outside source frame");

  // a response appears only out of the completion state
  a_rsp_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == S_DONE))
    else $error("response raised outside completion state");

  // an error response carries no pixel or coordinates
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == STATUS_RANGE) |->
      (rsp.pixel_out == '0) && (rsp.source_column == '0) && (rsp.source_row == '0))
    else $error("error response with nonzero payload");
`endif

endmodule
`default_nettype wire
